// ===== src/prc_pkg.sv =====
// Shared types, constants and helper functions of the point rotation unit.
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  // Coordinates are shifted left by this many bits while they are in the CORDIC.
  localparam int GUARD_BITS = 8;

  // Depth of both the inner work queue and the result queue.
  localparam int QUEUE_DEPTH = 4;

  // CORDIC gain compensation 0.607252935 in Q30.
  localparam logic [29:0] GAIN_K_Q30 = 30'd652032874;

  // Half of pi/2 in Q30, rounded down. It is the rounding offset of the quadrant count.
  localparam logic signed [34:0] HALF_PI_HALF = 35'sd843314856;

  // atan(2^-i) in Q30, truncated.
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
    30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
  };

  // Quarter turns applied to the offset before the CORDIC.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } prc_quad_t;

  // Status of one queue as seen by its producer and its consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } prc_q_stat_t;

  // Multiples of pi/2 in Q30 for the quarter counts that the angle range can give.
  function automatic logic signed [34:0] hp_mult(input logic signed [3:0] k);
    logic signed [34:0] r;
    unique case (k)
      -4'sd6:  r = -35'sd10119778278;
      -4'sd5:  r = -35'sd8433148565;
      -4'sd4:  r = -35'sd6746518852;
      -4'sd3:  r = -35'sd5059889139;
      -4'sd2:  r = -35'sd3373259426;
      -4'sd1:  r = -35'sd1686629713;
      4'sd0:   r = 35'sd0;
      4'sd1:   r = 35'sd1686629713;
      4'sd2:   r = 35'sd3373259426;
      4'sd3:   r = 35'sd5059889139;
      4'sd4:   r = 35'sd6746518852;
      4'sd5:   r = 35'sd8433148565;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/prc_fifo.sv =====
// Small register-based queue with a count, used between the unit's parts.
`timescale 1ns / 1ps
`default_nettype none

module prc_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_i,
  input  wire [DATA_W-1:0]     data_i,
  input  wire                  pop_i,
  output logic [DATA_W-1:0]    data_o,
  output prc_pkg::prc_q_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_r == (AW+1)'(DEPTH));
  assign stat_o.empty = (cnt_r == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/prc_front.sv =====
// Front part: takes points, forms the offset, reduces the angle and folds the quadrant.
`timescale 1ns / 1ps
`default_nettype none

module prc_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             push_i,
  output logic                            full_o,
  input  wire signed [31:0]               point_x_i,
  input  wire signed [31:0]               point_y_i,
  input  wire signed [31:0]               center_x_i,
  input  wire signed [31:0]               center_y_i,
  input  wire signed [31:0]               turn_angle_i,
  input  wire prc_pkg::prc_q_stat_t       q_stat_i,
  output logic                            q_push_o,
  output logic [4*COORD_WIDTH+33:0]       q_data_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;

  logic en;

  // Stage 0: captured beat.
  logic                 v0_r;
  logic [W-1:0]         px0_r, py0_r, cx0_r, cy0_r;
  logic [31:0]          ang0_r;
  logic [W+31:0]        px_ext, py_ext, cx_ext, cy_ext;

  // Stage 1: offset and the angle in Q30.
  logic                 v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic [W-1:0]         cx1_r, cy1_r;
  logic signed [33:0]   a1_r, a1_nxt;
  logic signed [34:0]   am1_r, am1_nxt;

  // Stage 2: quarter count.
  logic                 v2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic [W-1:0]         cx2_r, cy2_r;
  logic signed [33:0]   a2_r;
  logic signed [3:0]    kp2_r, kp2_nxt;
  logic [3:0]           cnt;

  // Outgoing beat.
  logic signed [34:0]   z_wide;
  logic signed [DW-1:0] x_f, y_f;
  prc_pkg::prc_quad_t   quad;

  assign en       = !(v2_r && q_stat_i.full);
  assign full_o   = !en;
  assign q_push_o = v2_r && !q_stat_i.full;

  // A coordinate is the low W bits of its field; fields narrower than W are zero-filled.
  assign px_ext = {{W{1'b0}}, point_x_i};
  assign py_ext = {{W{1'b0}}, point_y_i};
  assign cx_ext = {{W{1'b0}}, center_x_i};
  assign cy_ext = {{W{1'b0}}, center_y_i};

  always_comb begin
    dx1_nxt = $signed({px0_r[W-1], px0_r}) - $signed({cx0_r[W-1], cx0_r});
    dy1_nxt = $signed({py0_r[W-1], py0_r}) - $signed({cy0_r[W-1], cy0_r});
    a1_nxt  = $signed({ang0_r, 2'b00});
    am1_nxt = $signed({a1_nxt[33], a1_nxt}) + prc_pkg::HALF_PI_HALF;
  end

  // The quarter count is the largest k with k * pi/2 at or below the shifted angle.
  always_comb begin
    cnt = '0;
    for (int m = -5; m <= 5; m++) begin
      if (am1_r >= prc_pkg::hp_mult(4'(m))) begin
        cnt = cnt + 4'd1;
      end
    end
    kp2_nxt = $signed(cnt - 4'd6);
  end

  always_comb begin
    z_wide = $signed({a2_r[33], a2_r}) - prc_pkg::hp_mult(kp2_r);
    quad   = prc_pkg::prc_quad_t'(kp2_r[1:0]);
    unique case (quad)
      prc_pkg::QUAD_0: begin
        x_f = dx2_r;
        y_f = dy2_r;
      end
      prc_pkg::QUAD_1: begin
        x_f = -dy2_r;
        y_f = dx2_r;
      end
      prc_pkg::QUAD_2: begin
        x_f = -dx2_r;
        y_f = -dy2_r;
      end
      prc_pkg::QUAD_3: begin
        x_f = dy2_r;
        y_f = -dx2_r;
      end
      default: begin
        x_f = dx2_r;
        y_f = dy2_r;
      end
    endcase
  end

  assign q_data_o = {x_f, y_f, z_wide[31:0], cx2_r, cy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= push_i;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r  <= px_ext[W-1:0];
      py0_r  <= py_ext[W-1:0];
      cx0_r  <= cx_ext[W-1:0];
      cy0_r  <= cy_ext[W-1:0];
      ang0_r <= turn_angle_i;
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
      cx1_r  <= cx0_r;
      cy1_r  <= cy0_r;
      a1_r   <= a1_nxt;
      am1_r  <= am1_nxt;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      a2_r   <= a1_r;
      kp2_r  <= kp2_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/prc_back.sv =====
// Back part: CORDIC micro-rotation pipeline, gain compensation, rounding and clipping.
`timescale 1ns / 1ps
`default_nettype none

module prc_back #(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire prc_pkg::prc_q_stat_t  q_stat_i,
  input  wire [4*COORD_WIDTH+33:0]   q_data_i,
  output logic                       q_pop_o,
  input  wire                        res_full_i,
  output logic                       res_v_o,
  output logic [31:0]                res_x_o,
  output logic [31:0]                res_y_o,
  output logic                       res_sat_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int G  = prc_pkg::GUARD_BITS;
  localparam int XW = W + 11;
  localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int RW = W + 5;
  localparam int QW = 4 * W + 34;

  logic en;

  logic signed [DW-1:0] x_in, y_in;
  logic signed [31:0]   z_in;
  logic [W-1:0]         cx_in, cy_in;

  // CORDIC stages.
  logic                 v_r  [NS+1];
  logic signed [XW-1:0] x_r  [NS+1];
  logic signed [XW-1:0] y_r  [NS+1];
  logic signed [31:0]   z_r  [NS+1];
  logic [W-1:0]         cx_r [NS+1];
  logic [W-1:0]         cy_r [NS+1];
  logic signed [XW-1:0] x_nxt [NS];
  logic signed [XW-1:0] y_nxt [NS];
  logic signed [31:0]   z_nxt [NS];
  logic signed [XW-1:0] xs, ys;
  logic signed [31:0]   at;

  // Gain multiply: partial products.
  logic                 vm1_r;
  logic [59:0]          xe, ye;
  logic signed [60:0]   phx_r, phy_r, phx_nxt, phy_nxt;
  logic [59:0]          plx_r, ply_r, plx_nxt, ply_nxt;
  logic [W-1:0]         cx1_r, cy1_r;

  // Gain multiply: sum.
  logic                 vm2_r;
  logic [60:0]          tx, ty;
  logic signed [61:0]   sx, sy;
  logic signed [XW-1:0] gx_r, gy_r;
  logic [W-1:0]         cx2_r, cy2_r;

  // Guard-bit rounding and centre.
  logic                 vm3_r;
  logic signed [XW:0]   grx, gry;
  logic signed [RW-1:0] rx_r, ry_r, rx_nxt, ry_nxt;

  // Clipping.
  logic                 pos_x, neg_x, pos_y, neg_y;
  logic [W-1:0]         cl_x, cl_y;
  logic [W+31:0]        ox_ext, oy_ext;

  assign en      = !(vm3_r && res_full_i);
  assign q_pop_o = en && !q_stat_i.empty;
  assign res_v_o = vm3_r;

  assign x_in  = $signed(q_data_i[QW-1 -: DW]);
  assign y_in  = $signed(q_data_i[QW-DW-1 -: DW]);
  assign z_in  = $signed(q_data_i[2*W+31 -: 32]);
  assign cx_in = q_data_i[2*W-1 -: W];
  assign cy_in = q_data_i[W-1:0];

  always_comb begin
    xs = '0;
    ys = '0;
    at = '0;
    for (int i = 0; i < NS; i++) begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      at = $signed({2'b00, prc_pkg::ATAN_Q30[i]});
      if (!z_r[i][31]) begin
        x_nxt[i] = x_r[i] - ys;
        y_nxt[i] = y_r[i] + xs;
        z_nxt[i] = z_r[i] - at;
      end else begin
        x_nxt[i] = x_r[i] + ys;
        y_nxt[i] = y_r[i] - xs;
        z_nxt[i] = z_r[i] + at;
      end
    end
  end

  // The value is split at bit 30 so that each product stays within 30 by 31 bits.
  always_comb begin
    xe      = {{(60-XW){x_r[NS][XW-1]}}, x_r[NS]};
    ye      = {{(60-XW){y_r[NS][XW-1]}}, y_r[NS]};
    phx_nxt = $signed(xe[59:30]) * $signed({1'b0, prc_pkg::GAIN_K_Q30});
    phy_nxt = $signed(ye[59:30]) * $signed({1'b0, prc_pkg::GAIN_K_Q30});
    plx_nxt = xe[29:0] * prc_pkg::GAIN_K_Q30;
    ply_nxt = ye[29:0] * prc_pkg::GAIN_K_Q30;
  end

  always_comb begin
    tx = {1'b0, plx_r} + 61'(64'd1 << 29);
    ty = {1'b0, ply_r} + 61'(64'd1 << 29);
    sx = $signed({phx_r[60], phx_r}) + $signed({31'd0, tx[60:30]});
    sy = $signed({phy_r[60], phy_r}) + $signed({31'd0, ty[60:30]});
  end

  always_comb begin
    grx    = $signed({gx_r[XW-1], gx_r}) + $signed((XW+1)'(64'd1 << (G - 1)));
    gry    = $signed({gy_r[XW-1], gy_r}) + $signed((XW+1)'(64'd1 << (G - 1)));
    rx_nxt = $signed({grx[XW], grx[XW:G]}) + $signed({{(RW-W){cx2_r[W-1]}}, cx2_r});
    ry_nxt = $signed({gry[XW], gry[XW:G]}) + $signed({{(RW-W){cy2_r[W-1]}}, cy2_r});
  end

  always_comb begin
    pos_x  = !rx_r[RW-1] && (|rx_r[RW-2:W-1]);
    neg_x  = rx_r[RW-1] && !(&rx_r[RW-2:W-1]);
    pos_y  = !ry_r[RW-1] && (|ry_r[RW-2:W-1]);
    neg_y  = ry_r[RW-1] && !(&ry_r[RW-2:W-1]);
    cl_x   = pos_x ? {1'b0, {(W-1){1'b1}}} : (neg_x ? {1'b1, {(W-1){1'b0}}} : rx_r[W-1:0]);
    cl_y   = pos_y ? {1'b0, {(W-1){1'b1}}} : (neg_y ? {1'b1, {(W-1){1'b0}}} : ry_r[W-1:0]);
    ox_ext = {{32{cl_x[W-1]}}, cl_x};
    oy_ext = {{32{cl_y[W-1]}}, cl_y};
  end

  assign res_x_o   = ox_ext[31:0];
  assign res_y_o   = oy_ext[31:0];
  assign res_sat_o = pos_x || neg_x || pos_y || neg_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        v_r[i] <= 1'b0;
      end
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_stat_i.empty;
      for (int i = 0; i < NS; i++) begin
        v_r[i+1] <= v_r[i];
      end
      vm1_r <= v_r[NS];
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= $signed({{(XW-DW-G){x_in[DW-1]}}, x_in, {G{1'b0}}});
      y_r[0]  <= $signed({{(XW-DW-G){y_in[DW-1]}}, y_in, {G{1'b0}}});
      z_r[0]  <= z_in;
      cx_r[0] <= cx_in;
      cy_r[0] <= cy_in;
      for (int i = 0; i < NS; i++) begin
        x_r[i+1]  <= x_nxt[i];
        y_r[i+1]  <= y_nxt[i];
        z_r[i+1]  <= z_nxt[i];
        cx_r[i+1] <= cx_r[i];
        cy_r[i+1] <= cy_r[i];
      end
      phx_r <= phx_nxt;
      phy_r <= phy_nxt;
      plx_r <= plx_nxt;
      ply_r <= ply_nxt;
      cx1_r <= cx_r[NS];
      cy1_r <= cy_r[NS];
      gx_r  <= sx[XW-1:0];
      gy_r  <= sy[XW-1:0];
      cx2_r <= cx1_r;
      cy2_r <= cy1_r;
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/point_rotation_about_center_unit.sv =====
// Top level of the point rotation unit: rotates a point about a centre by an angle.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake        Beat contents
// -------   --------------   ---------------------------------------------------------
// input     push / full      in_point_x, in_point_y, in_center_x, in_center_y,
//                            in_turn_angle (Q16.16 coordinates, Q4.28 radians)
// result    empty / pop      out_rotated_x, out_rotated_y (Q16.16), out_saturated
//
// The unit takes one point per cycle while full is low and delivers one result per
// cycle in steady state while the reader pops. A result passes through three front
// stages, the inner queue, CORDIC_STEPS + 1 rotation stages, three stages of gain
// multiply and rounding, and the result queue.
// Reset clears every valid bit and both queues; no data is cleared and no sweep is needed.
// The front stalls only when the inner queue is full and the back only when the result
// queue is full, so a slow reader fills the queues before full is raised at the input.

module point_rotation_about_center_unit #(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  output logic               full,
  input  wire signed [31:0]  in_point_x,
  input  wire signed [31:0]  in_point_y,
  input  wire signed [31:0]  in_center_x,
  input  wire signed [31:0]  in_center_y,
  input  wire signed [31:0]  in_turn_angle,
  output logic               empty,
  input  wire                pop,
  output logic signed [31:0] out_rotated_x,
  output logic signed [31:0] out_rotated_y,
  output logic               out_saturated
);

  // Width of one beat in the inner queue: folded offsets, residual angle and the centre.
  localparam int MID_W = 4 * COORD_WIDTH + 34;
  localparam int RES_W = 65;

  prc_pkg::prc_q_stat_t mid_stat;
  prc_pkg::prc_q_stat_t out_stat;
  logic                 mid_push;
  logic                 mid_pop;
  logic [MID_W-1:0]     mid_wdata;
  logic [MID_W-1:0]     mid_rdata;
  logic                 res_v;
  logic                 res_push;
  logic [31:0]          res_x;
  logic [31:0]          res_y;
  logic                 res_sat;
  logic [RES_W-1:0]     res_rdata;

  // The front folds the offset by whole quarter turns, which leaves a residual angle
  // within plus or minus pi/4 for the CORDIC.
  prc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .full_o       (full),
    .point_x_i    (in_point_x),
    .point_y_i    (in_point_y),
    .center_x_i   (in_center_x),
    .center_y_i   (in_center_y),
    .turn_angle_i (in_turn_angle),
    .q_stat_i     (mid_stat),
    .q_push_o     (mid_push),
    .q_data_o     (mid_wdata)
  );

  // The inner queue lets the front keep taking beats while the back is held.
  prc_fifo #(
    .DATA_W (MID_W),
    .DEPTH  (prc_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (mid_push),
    .data_i (mid_wdata),
    .pop_i  (mid_pop),
    .data_o (mid_rdata),
    .stat_o (mid_stat)
  );

  // The back runs one micro-rotation per stage, then compensates the gain, rounds
  // away the guard bits, adds the centre back and clips to the coordinate range.
  prc_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat_i   (mid_stat),
    .q_data_i   (mid_rdata),
    .q_pop_o    (mid_pop),
    .res_full_i (out_stat.full),
    .res_v_o    (res_v),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_sat_o  (res_sat)
  );

  assign res_push = res_v && !out_stat.full;

  // The result queue holds finished results so that the back can keep moving while
  // the reader waits.
  prc_fifo #(
    .DATA_W (RES_W),
    .DEPTH  (prc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (res_push),
    .data_i ({res_x, res_y, res_sat}),
    .pop_i  (pop),
    .data_o (res_rdata),
    .stat_o (out_stat)
  );

  assign empty         = out_stat.empty;
  assign out_rotated_x = $signed(res_rdata[64:33]);
  assign out_rotated_y = $signed(res_rdata[32:1]);
  assign out_saturated = res_rdata[0];

  // The front never offers a beat to a full inner queue.
  a_mid_no_overfill: assert property (
    @(posedge clk) disable iff (!rst_n)
    mid_stat.full |-> !mid_push
  ) else $error("front pushed into a full inner queue");

  // A finished result that meets a full result queue stays in the back.
  a_res_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    res_v && out_stat.full |=> res_v
  ) else $error("result left the back while the result queue was full");

  // The result queue only becomes non-empty after the back offered a result.
  a_out_from_back: assert property (
    @(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(res_v)
  ) else $error("result appeared without a finished result from the back");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench of the point rotation unit: queue handshakes and a bit-true predictor.
`timescale 1ns / 1ps

module testbench;

  // The unit is built with its default sizes; the predictor follows the same numbers.
  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 24;

  // Constants of the rotation: Q30 values, the guard-bit shift and rounding, the coordinate bounds.
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint HALF_Q30     = 64'sd536870912;
  localparam int     GUARD_SHIFT  = 8;
  localparam longint GUARD_ROUND  = 64'sd128;
  localparam longint COORD_MAX    = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam longint COORD_MIN    = -COORD_MAX - 64'sd1;

  // atan(2^-i) in Q30, truncated, one entry per micro-rotation.
  localparam longint ARCTAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
    64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
  };

  // Handy angles in Q4.28 radians and coordinates in Q16.16.
  localparam logic signed [31:0] ANG_QUARTER = 32'sd421657428;
  localparam logic signed [31:0] ANG_HALF    = 32'sd843314856;
  localparam logic signed [31:0] ANG_3QUART  = 32'sd1264972284;
  localparam logic signed [31:0] ANG_FULL    = 32'sd1686629713;
  // The last angle that still folds down, and the first that folds up, at +-pi/4.
  localparam logic signed [31:0] ANG_FOLD_LO = 32'sd210828714;
  localparam logic signed [31:0] ANG_FOLD_HI = 32'sd210828715;
  localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;
  localparam logic signed [31:0] MAX_COORD   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_COORD   = 32'sh8000_0000;

  // Run control: watchdog limit, reader hold-off, tail after the last result, idle percent, point total.
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = CORDIC_STEPS + 24;
  localparam int IDLE_PERCENT  = 12;
  localparam int RANDOM_POINTS = 720;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               sat;
  } rotated_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input side of the unit; every input is known from time zero.
  logic              push = 1'b0;
  logic              full;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic signed [31:0] in_turn_angle = '0;

  // Result side of the unit.
  logic              empty;
  logic              pop = 1'b0;
  logic signed [31:0] out_rotated_x;
  logic signed [31:0] out_rotated_y;
  logic              out_saturated;

  // Results that the predictor has worked out and the unit still owes, oldest first.
  rotated_point_t pending_rotations[$];

  int  error_count = 0;
  int  points_sent = 0;
  int  points_checked = 0;
  int  saturated_seen = 0;
  int  idle_cycles = 0;
  bit  steady_flow = 1'b0;   // while set, neither side idles
  bit  hold_request = 1'b0;  // asks the reader for one long hold-off
  int  hold_left = 0;

  point_rotation_about_center_unit #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_turn_angle (in_turn_angle),
    .empty         (empty),
    .pop           (pop),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_saturated (out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A coordinate field is read as a signed COORD_WIDTH-bit value from its low bits.
  function automatic longint widen_coord(input logic [31:0] field);
    longint w;
    w = longint'({32'b0, field});
    return (w <<< (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
  endfunction

  // Gain compensation, removal of the guard bits with rounding, the centre added back,
  // and clipping to the coordinate range.
  function automatic logic signed [31:0] settle_coord(input longint v, input longint centre,
                                                      output bit clipped);
    longint whole;
    longint frac;
    longint scaled;
    longint placed;
    whole = v >>> 30;
    frac = v - whole * ONE_Q30;
    scaled = whole * GAIN_Q30 + ((frac * GAIN_Q30 + HALF_Q30) >>> 30);
    placed = ((scaled + GUARD_ROUND) >>> GUARD_SHIFT) + centre;
    clipped = 1'b0;
    if (placed > COORD_MAX) begin
      clipped = 1'b1;
      placed = COORD_MAX;
    end else if (placed < COORD_MIN) begin
      clipped = 1'b1;
      placed = COORD_MIN;
    end
    return placed[31:0];
  endfunction

  // Bit-true prediction of one rotated point.
  function automatic rotated_point_t predict_rotation(input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic signed [31:0] cx,
                                                      input logic signed [31:0] cy,
                                                      input logic signed [31:0] ang);
    longint pxl, pyl, cxl, cyl;
    longint wrapped, quarters, resid;
    longint offs_x, offs_y, x, y, nx;
    logic [1:0] qbits;
    prc_pkg::prc_quad_t quad;
    int i;
    bit clip_x, clip_y;
    rotated_point_t res;
    pxl = widen_coord(px);
    pyl = widen_coord(py);
    cxl = widen_coord(cx);
    cyl = widen_coord(cy);
    // Widen the angle to Q30 and lift it above zero by six quarter turns, so that the
    // rounded quarter count comes from a plain positive division.
    wrapped = longint'(ang) * 4 + 6 * HALF_PI_Q30;
    quarters = (wrapped + HALF_PI_Q30 / 2) / HALF_PI_Q30;
    resid = wrapped - quarters * HALF_PI_Q30;
    qbits = quarters[1:0] + 2'd2;
    quad = prc_pkg::prc_quad_t'(qbits);
    offs_x = pxl - cxl;
    offs_y = pyl - cyl;
    case (quad)
      prc_pkg::QUAD_1: begin
        x = -offs_y;
        y = offs_x;
      end
      prc_pkg::QUAD_2: begin
        x = -offs_x;
        y = -offs_y;
      end
      prc_pkg::QUAD_3: begin
        x = offs_y;
        y = -offs_x;
      end
      default: begin
        x = offs_x;
        y = offs_y;
      end
    endcase
    x = x * (64'sd1 <<< GUARD_SHIFT);
    y = y * (64'sd1 <<< GUARD_SHIFT);
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (resid >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        resid = resid - ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        resid = resid + ARCTAN_Q30[i];
      end
      x = nx;
    end
    res.rx = settle_coord(x, cxl, clip_x);
    res.ry = settle_coord(y, cyl, clip_y);
    res.sat = clip_x | clip_y;
    return res;
  endfunction

  // Offers one point and waits until the unit takes the beat. A random gap may come first,
  // so that idle cycles land on every phase of the pipeline.
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic signed [31:0] ang);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99, 0) < IDLE_PERCENT) begin
      gap = 1;
    end
    while (gap > 0) begin
      push <= 1'b0;
      @(posedge clk);
      gap--;
    end
    push <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_center_x <= cx;
    in_center_y <= cy;
    in_turn_angle <= ang;
    @(posedge clk);
    // full is read before the unit updates it at this edge, so it tells whether the
    // beat was taken at this very edge.
    while (full) begin
      @(posedge clk);
    end
    pending_rotations.push_back(predict_rotation(px, py, cx, cy, ang));
    points_sent++;
  endtask

  // Quarter turns are folded exactly, so a unit vector lands on the axes.
  task automatic test_quarter_turns();
    send_point(ONE_Q16, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_point(ONE_Q16, 32'sd0, 32'sd0, 32'sd0, ANG_QUARTER);
    send_point(ONE_Q16, 32'sd0, 32'sd0, 32'sd0, ANG_HALF);
    send_point(ONE_Q16, 32'sd0, 32'sd0, 32'sd0, -ANG_QUARTER);
    send_point(ONE_Q16, ONE_Q16, 32'sd0, 32'sd0, ANG_3QUART);
    send_point(32'sh0003_8000, -32'sh0002_4000, ONE_Q16, ONE_Q16, ANG_FULL);
  endtask

  // Largest and smallest angles, far beyond one turn, both sides of the fold at pi/4, and +-1 LSB.
  task automatic test_angle_extremes();
    send_point(32'sh0003_8000, -32'sh0002_4000, ONE_Q16, -ONE_Q16, 32'sh7FFF_FFFF);
    send_point(32'sh0003_8000, -32'sh0002_4000, ONE_Q16, -ONE_Q16, 32'sh8000_0000);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, ANG_FOLD_LO);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, ANG_FOLD_HI);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, -ANG_FOLD_LO);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, -ANG_FOLD_HI);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd1);
    send_point(32'sh0005_0000, 32'sh0001_0000, 32'sd0, 32'sd0, -32'sd1);
  endtask

  // Extreme coordinates: offsets of the full 33-bit span, which clip on one or both
  // axes, and a point sitting on its centre, which must come back unchanged.
  task automatic test_coordinate_extremes();
    send_point(MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, 32'sd0);
    send_point(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, ANG_HALF);
    send_point(MAX_COORD, MIN_COORD, MAX_COORD, MIN_COORD, 32'sd123456789);
    send_point(MAX_COORD, 32'sd0, 32'sd0, 32'sd0, ANG_QUARTER);
    send_point(MAX_COORD, MIN_COORD, 32'sd0, 32'sd0, ANG_QUARTER / 2);
    send_point(MIN_COORD, 32'sd0, MAX_COORD, 32'sd0, -ANG_QUARTER / 3);
    send_point(32'sd0, MAX_COORD, 32'sd0, MIN_COORD, ANG_3QUART);
  endtask

  // Random points. Most sit a modest distance from a modest centre, so the rotation itself is
  // what gets checked; some sit near a centre anywhere in the field range, and the rest spread
  // over the whole field range and push the offsets into saturation.
  task automatic test_random_points(input int count);
    int n;
    int mode;
    logic signed [31:0] cx, cy, px, py, ang;
    for (n = 0; n < count; n++) begin
      mode = $urandom_range(99, 0);
      ang = $urandom();
      if (mode < 8) begin
        // Near a fold boundary, on either side and in any turn.
        ang = ANG_FOLD_LO + $signed($urandom_range(3, 0)) +
              $signed($urandom_range(8, 0) - 4) * ANG_QUARTER;
      end
      if (mode < 70) begin
        cx = $signed($urandom()) >>> $urandom_range(8, 2);
        cy = $signed($urandom()) >>> $urandom_range(8, 2);
        px = cx + ($signed($urandom()) >>> $urandom_range(20, 4));
        py = cy + ($signed($urandom()) >>> $urandom_range(20, 4));
      end else if (mode < 85) begin
        cx = $urandom();
        cy = $urandom();
        px = cx + ($signed($urandom()) >>> 12);
        py = cy + ($signed($urandom()) >>> 12);
      end else begin
        cx = $urandom();
        cy = $urandom();
        px = $urandom();
        py = $urandom();
      end
      send_point(px, py, cx, cy, ang);
    end
  endtask

  // The reader holds off for a long stretch while points keep coming, so the inner queue and
  // the result queue fill and full must stall the input without losing or repeating a beat.
  task automatic test_back_pressure();
    hold_request = 1'b1;
    test_random_points(90);
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    test_random_points(150);
    steady_flow = 1'b0;
  endtask

  // Reader: pops at random, except during the hold-off and the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      pop <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      hold_request = 1'b0;
    end else begin
      pop <= steady_flow || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  // Result checker: each result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    rotated_point_t want;
    if (rst_n && pop && !empty) begin
      if (pending_rotations.size() == 0) begin
        $error("rotated point arrived with none outstanding: x %0d y %0d sat %0d",
               out_rotated_x, out_rotated_y, out_saturated);
        error_count++;
      end else begin
        want = pending_rotations.pop_front();
        if (out_rotated_x !== want.rx) begin
          $error("rotated_x mismatch: expected %0d, actual %0d", want.rx, out_rotated_x);
          error_count++;
        end
        if (out_rotated_y !== want.ry) begin
          $error("rotated_y mismatch: expected %0d, actual %0d", want.ry, out_rotated_y);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated mismatch: expected %0d, actual %0d", want.sat, out_saturated);
          error_count++;
        end
        points_checked++;
        if (want.sat) begin
          saturated_seen++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without a beat on either side ends the run.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: watchdog expired with %0d rotated points outstanding",
               pending_rotations.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quarter_turns();
    test_angle_extremes();
    test_coordinate_extremes();
    test_back_pressure();
    test_steady_stream();
    test_random_points(RANDOM_POINTS - 240);

    push <= 1'b0;
    while (pending_rotations.size() != 0) begin
      @(posedge clk);
    end
    // Any stray result beyond the last one is caught by the checker during the tail.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d points rotated and checked bit for bit, %0d of them clipped,",
             points_checked, saturated_seen);
    $display("tb: with random idling on both sides, one long reader hold-off and a steady run");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/prc_pkg.sv
src/prc_fifo.sv
src/prc_front.sv
src/prc_back.sv
src/point_rotation_about_center_unit.sv
verif/testbench.sv
